@@ design/tcts_pkg.sv @@
// Shared types, character codes and helpers for the template comment token scanner.
package tcts_pkg;

  typedef enum logic [2:0] {
    VERDICT_IDLE = 3'd0,
    VERDICT_PEND = 3'd1,
    VERDICT_DONE = 3'd2,
    VERDICT_NOT  = 3'd3,
    VERDICT_KW   = 3'd4
  } verdict_e;

  localparam int unsigned LenW = 16;

  localparam logic [7:0] ChEot    = 8'h00;
  localparam logic [7:0] ChLBrace = 8'h7B;  // '{'
  localparam logic [7:0] ChRBrace = 8'h7D;  // '}'
  localparam logic [7:0] ChLBrack = 8'h5B;  // '['
  localparam logic [7:0] ChRBrack = 8'h5D;  // ']'
  localparam logic [7:0] ChBang   = 8'h21;  // '!'
  localparam logic [7:0] ChDash   = 8'h2D;  // '-'
  localparam logic [7:0] ChLowI   = 8'h69;  // 'i'
  localparam logic [7:0] ChLowU   = 8'h75;  // 'u'

  localparam logic [3:0] KwLenInclude  = 4'd7;
  localparam logic [3:0] KwLenUnsecure = 4'd8;

  // Space, tab, carriage return or line feed.
  function automatic logic is_ws(input logic [7:0] c);
    return c inside {8'h20, 8'h09, 8'h0D, 8'h0A};
  endfunction

  // Keyword text: choice low spells "include", choice high spells "unsecure".
  function automatic logic [7:0] kw_char(input logic choice, input logic [2:0] idx);
    logic [7:0] c;
    if (!choice) begin
      case (idx)
        3'd0:    c = 8'h69;  // i
        3'd1:    c = 8'h6E;  // n
        3'd2:    c = 8'h63;  // c
        3'd3:    c = 8'h6C;  // l
        3'd4:    c = 8'h75;  // u
        3'd5:    c = 8'h64;  // d
        3'd6:    c = 8'h65;  // e
        default: c = 8'h00;
      endcase
    end else begin
      case (idx)
        3'd0:    c = 8'h75;  // u
        3'd1:    c = 8'h6E;  // n
        3'd2:    c = 8'h73;  // s
        3'd3:    c = 8'h65;  // e
        3'd4:    c = 8'h63;  // c
        3'd5:    c = 8'h75;  // u
        3'd6:    c = 8'h72;  // r
        default: c = 8'h65;  // e
      endcase
    end
    return c;
  endfunction

endpackage

@@ design/template_comment_token_scanner_top.sv @@
// Top level of the template comment token scanner: handshake and result register.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+----------------------------
//   in      | into      | in_valid_i / in_stall_o | ch_i, first_i, allowed_i
//   out     | out of    | out_valid_o / out_stall_i | verdict_o, length_o
//
// The scan state machine updates and the result register loads at the edge
// that accepts a character request, so the result is offered in the next
// cycle. One request per cycle is sustained; the single result register
// is what bounds throughput when the output side stalls.
// Reset (rst_ni low, asynchronous) empties the result register and puts the
// scanner in idle with a zero character count.
// in_stall_o is high only while a result waits and the output side stalls;
// a result taken in the same cycle frees the register for the next request.
module template_comment_token_scanner_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [7:0]                ch_i,
  input  logic                      first_i,
  input  logic                      allowed_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [2:0]                verdict_o,
  output logic [tcts_pkg::LenW-1:0] length_o
);

  logic               out_valid_q, out_valid_d;
  logic               in_accept;
  logic               out_accept;
  tcts_pkg::verdict_e verdict;

  // Hold the request while a result waits and the output side stalls.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_accept = out_valid_q && !out_stall_i;

  // Advance the result register on every accepted request; drop it once taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (in_accept) begin
      out_valid_d = 1'b1;
    end else if (out_accept) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  tcts_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (in_accept),
    .ch_i      (ch_i),
    .first_i   (first_i),
    .allowed_i (allowed_i),
    .verdict_o (verdict),
    .length_o  (length_o)
  );

  assign out_valid_o = out_valid_q;
  assign verdict_o   = verdict;

  // An idle result always reports a zero count.
  a_idle_len_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && verdict_o == tcts_pkg::VERDICT_IDLE) |-> (length_o == '0))
    else $error("idle result with nonzero length");

  // A start that is not allowed is rejected with nothing consumed.
  a_not_allowed : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && first_i && !allowed_i) |=>
      (out_valid_o && verdict_o == tcts_pkg::VERDICT_NOT && length_o == '0))
    else $error("disallowed start not rejected");

  // An allowed start on '{' opens an attempt with one character consumed.
  a_open_attempt : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && first_i && allowed_i && ch_i == tcts_pkg::ChLBrace) |=>
      (verdict_o == tcts_pkg::VERDICT_PEND && length_o == 16'd1))
    else $error("attempt did not open");

  // A waiting result that is not taken and not replaced keeps its value.
  a_result_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> ($stable(verdict_o) && $stable(length_o)))
    else $error("stalled result changed");

endmodule

@@ design/tcts_core.sv @@
// Scan state machine and result register of the template comment token scanner.
module tcts_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      load_i,
  input  logic [7:0]                ch_i,
  input  logic                      first_i,
  input  logic                      allowed_i,
  output tcts_pkg::verdict_e        verdict_o,
  output logic [tcts_pkg::LenW-1:0] length_o
);

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_LBRACK = 3'd1,
    PH_DASH   = 3'd2,
    PH_BANG   = 3'd3,
    PH_WS     = 3'd4,
    PH_KW     = 3'd5,
    PH_BODY   = 3'd6
  } phase_e;

  phase_e                    phase_q, phase_d;
  logic                      choice_q, choice_d;
  logic [3:0]                idx_q, idx_d;
  logic                      brk_q, brk_d;
  logic [tcts_pkg::LenW-1:0] cons_q, cons_d;
  tcts_pkg::verdict_e        verdict_q, verdict_d;
  logic [tcts_pkg::LenW-1:0] length_q, length_d;

  logic [tcts_pkg::LenW-1:0] cons_base, cons_inc;
  logic                      do_take, do_body, do_finish, clear_cons;
  logic [3:0]                kw_len;

  assign cons_base = first_i ? '0 : cons_q;
  assign cons_inc  = (&cons_base) ? cons_base : cons_base + tcts_pkg::LenW'(1);
  assign kw_len    = choice_q ? tcts_pkg::KwLenUnsecure : tcts_pkg::KwLenInclude;

  always_comb begin
    phase_d    = phase_q;
    choice_d   = choice_q;
    idx_d      = idx_q;
    brk_d      = brk_q;
    verdict_d  = tcts_pkg::VERDICT_PEND;
    do_take    = 1'b0;
    do_body    = 1'b0;
    do_finish  = 1'b0;
    clear_cons = 1'b0;

    if (first_i) begin
      choice_d = 1'b0;
      idx_d    = '0;
      brk_d    = 1'b0;
      if (!allowed_i || ch_i != tcts_pkg::ChLBrace) begin
        do_finish = 1'b1;
        verdict_d = tcts_pkg::VERDICT_NOT;
      end else begin
        do_take = 1'b1;
        phase_d = PH_LBRACK;
      end
    end else begin
      case (phase_q)
        PH_LBRACK: begin
          if (ch_i == tcts_pkg::ChLBrack) begin
            do_take = 1'b1;
            phase_d = PH_DASH;
          end else begin
            do_finish = 1'b1;
            verdict_d = tcts_pkg::VERDICT_NOT;
          end
        end
        PH_DASH: begin
          if (ch_i == tcts_pkg::ChDash) begin
            do_take = 1'b1;
            phase_d = PH_BANG;
          end else if (ch_i == tcts_pkg::ChBang) begin
            do_take = 1'b1;
            phase_d = PH_WS;
          end else begin
            do_finish = 1'b1;
            verdict_d = tcts_pkg::VERDICT_NOT;
          end
        end
        PH_BANG: begin
          if (ch_i == tcts_pkg::ChBang) begin
            do_take = 1'b1;
            phase_d = PH_WS;
          end else begin
            do_finish = 1'b1;
            verdict_d = tcts_pkg::VERDICT_NOT;
          end
        end
        PH_WS: begin
          if (tcts_pkg::is_ws(ch_i)) begin
            do_take = 1'b1;
          end else if (ch_i == tcts_pkg::ChLowI || ch_i == tcts_pkg::ChLowU) begin
            do_take  = 1'b1;
            choice_d = (ch_i == tcts_pkg::ChLowU);
            idx_d    = 4'd1;
            phase_d  = PH_KW;
          end else begin
            do_body = 1'b1;
          end
        end
        PH_KW: begin
          if (idx_q >= kw_len) begin
            if (tcts_pkg::is_ws(ch_i) || ch_i == tcts_pkg::ChDash ||
                ch_i == tcts_pkg::ChRBrack) begin
              do_finish = 1'b1;
              verdict_d = tcts_pkg::VERDICT_KW;
            end else begin
              do_body = 1'b1;
            end
          end else if (ch_i == tcts_pkg::kw_char(choice_q, idx_q[2:0])) begin
            do_take = 1'b1;
            idx_d   = idx_q + 4'd1;
          end else begin
            do_body = 1'b1;
          end
        end
        PH_BODY: begin
          do_body = 1'b1;
        end
        default: begin
          phase_d    = PH_IDLE;
          clear_cons = 1'b1;
          verdict_d  = tcts_pkg::VERDICT_IDLE;
        end
      endcase
    end

    // Body character: end of text rejects, "]}" closes the comment.
    if (do_body) begin
      phase_d = PH_BODY;
      if (ch_i == tcts_pkg::ChEot) begin
        do_finish = 1'b1;
        verdict_d = tcts_pkg::VERDICT_NOT;
      end else begin
        do_take = 1'b1;
        if (brk_q && ch_i == tcts_pkg::ChRBrace) begin
          do_finish = 1'b1;
          verdict_d = tcts_pkg::VERDICT_DONE;
        end else begin
          brk_d = (ch_i == tcts_pkg::ChRBrack);
        end
      end
    end

    if (do_finish) begin
      phase_d = PH_IDLE;
      idx_d   = '0;
      brk_d   = 1'b0;
    end

    if (clear_cons) begin
      cons_d = '0;
    end else if (do_take) begin
      cons_d = cons_inc;
    end else begin
      cons_d = cons_base;
    end

    length_d = (verdict_d == tcts_pkg::VERDICT_IDLE) ? '0 : cons_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      choice_q  <= 1'b0;
      idx_q     <= '0;
      brk_q     <= 1'b0;
      cons_q    <= '0;
      verdict_q <= tcts_pkg::VERDICT_IDLE;
      length_q  <= '0;
    end else if (load_i) begin
      phase_q   <= phase_d;
      choice_q  <= choice_d;
      idx_q     <= idx_d;
      brk_q     <= brk_d;
      cons_q    <= cons_d;
      verdict_q <= verdict_d;
      length_q  <= length_d;
    end
  end

  assign verdict_o = verdict_q;
  assign length_o  = length_q;

endmodule
